// ===== hdl/grid_dda_ray_caster_macros.svh =====
// Assertion macros for the ray caster.
`ifndef GRID_DDA_RAY_CASTER_MACROS_SVH
`define GRID_DDA_RAY_CASTER_MACROS_SVH
`ifndef SYNTHESIS
`define GDRC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assert failed");
`define GDRC_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assert failed");
`else
`define GDRC_ASSERT(label, clk, rst_n, prop)
`define GDRC_ASSERT_NR(label, clk, prop)
`endif
`endif

// ===== hdl/gdrc_pkg.sv =====
`default_nettype none
package gdrc_pkg;
  localparam int MapSize = 16;
  localparam int MapW = $clog2(MapSize);
  localparam int CellCnt = MapSize * MapSize;
  localparam int CellW = $clog2(CellCnt);
  localparam int ScreenWidth = 640;
  localparam int ScreenHeight = 480;
  localparam int OneQ12 = 4096;
  localparam logic [19:0] MaxDist = 20'hFFFFF;

  // ScreenWidth == 5 << ScreenWidthShift; RecipFive == ceil(2**RecipShift / 5)
  localparam int ScreenWidthShift = 7;
  localparam logic [19:0] RecipFive = 20'd838861;
  localparam int RecipShift = 22;

  localparam logic [2:0] RegPosX = 3'd0;
  localparam logic [2:0] RegPosY = 3'd1;
  localparam logic [2:0] RegDirX = 3'd2;
  localparam logic [2:0] RegDirY = 3'd3;
  localparam logic [2:0] RegPlaneX = 3'd4;
  localparam logic [2:0] RegPlaneY = 3'd5;

  typedef struct packed {
    logic        mode;
    logic [3:0]  cell_row;
    logic [3:0]  cell_col;
    logic        cell_wall;
    logic [9:0]  column;
  } in_item_t;

  typedef struct packed {
    logic [9:0]         out_column;
    logic               wall_side;
    logic [3:0]         hit_row;
    logic [3:0]         hit_col;
    logic [19:0]        perp_dist;
    logic signed [15:0] line_top;
    logic signed [15:0] line_bottom;
    logic               escaped;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [15:0] data;
  } cfg_item_t;

  typedef enum logic [3:0] {
    StIdle, StRayMul, StRayAdd, StInit, StCmp, StStep, StRead, StTest,
    StDist, StDivA, StDivB, StDone
  } state_e;

  typedef struct packed {
    logic        start;
    logic [39:0] num;
    logic [20:0] den;
  } div_req_t;

  function automatic logic start_wall(input int r, input int c);
    logic [9:0] rows [10];
    rows[0] = 10'b1111111111; rows[1] = 10'b1000010011;
    rows[2] = 10'b1010000001; rows[3] = 10'b1000000001;
    rows[4] = 10'b1000000001; rows[5] = 10'b1100000011;
    rows[6] = 10'b1000000001; rows[7] = 10'b1000000001;
    rows[8] = 10'b1100010011; rows[9] = 10'b1111111111;
    if (r < 10 && c < 10) return rows[r][c];
    return 1'b0;
  endfunction
endpackage
`default_nettype wire

// ===== hdl/gdrc_if.sv =====
`default_nettype none
interface gdrc_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/gdrc_div.sv =====
`default_nettype none
module gdrc_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire gdrc_pkg::div_req_t req_i,
  output logic                   busy_o,
  output logic [39:0]            quot_o
);
  import gdrc_pkg::*;
  logic [39:0] q_q, q_d;
  logic [20:0] r_q, r_d, den_q, den_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [21:0] trial;

  always_comb begin
    q_d = q_q;
    r_d = r_q;
    den_d = den_q;
    cnt_d = cnt_q;
    trial = {r_q, q_q[39]} - {1'b0, den_q};
    if (req_i.start) begin
      q_d = req_i.num;
      r_d = '0;
      den_d = req_i.den;
      cnt_d = 6'd40;
    end else if (cnt_q != 6'd0) begin
      cnt_d = cnt_q - 6'd1;
      if (!trial[21]) begin
        r_d = trial[20:0];
        q_d = {q_q[38:0], 1'b1};
      end else begin
        r_d = {r_q[19:0], q_q[39]};
        q_d = {q_q[38:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
    r_q <= r_d;
    den_q <= den_d;
  end

  assign busy_o = (cnt_q != 6'd0);
  assign quot_o = q_q;
endmodule
`default_nettype wire

// ===== hdl/grid_dda_ray_caster.sv =====
// Grid DDA ray caster. A write beat (mode 0) sets one wall bit of the 16x16
// grid. A cast beat (mode 1) passes the setup steps (ray multiply, ray add,
// init, compare), walks the grid one cell at a time (step, registered grid
// read, test), then runs up to two restoring divisions (distance and slice
// height) on one shared divider, and loads the result into the output
// register. The block takes no beat while a cast is at work; a result waits
// in the output register while the next beat may be accepted, and a
// following cast holds in its done state until that register is free.
`default_nettype none
`include "grid_dda_ray_caster_macros.svh"
module grid_dda_ray_caster (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  gdrc_if.sink      in_if,
  gdrc_if.sink      cfg_if,
  gdrc_if.source    out_if
);
  import gdrc_pkg::*;

  state_e state_q, state_d;
  logic [CellCnt-1:0] map_q;
  logic [15:0] pos_x_q, pos_y_q;
  logic signed [15:0] dir_x_q, dir_y_q, plane_x_q, plane_y_q;

  logic [9:0] col_q;
  logic signed [15:0] rx_q, ry_q;
  logic signed [27:0] px_q, py_q;
  logic [MapW:0] mx_q, my_q;
  logic [16:0] nx_q, ny_q;
  logic side_q, esc_q, wall_q;
  logic [19:0] perp_q;
  logic signed [15:0] top_q, bottom_q;
  logic [15:0] abs_rx, abs_ry;
  logic row_step;
  logic [32:0] lhs, rhs;
  logic signed [11:0] tcol;
  logic [19:0] perp_new;
  logic out_free;

  out_item_t out_q;
  logic out_valid_q;

  div_req_t div_req;
  logic div_busy;
  logic [39:0] div_quot;

  gdrc_div u_div (.clk_i, .rst_ni, .req_i(div_req), .busy_o(div_busy), .quot_o(div_quot));

  assign in_if.ready = (state_q == StIdle);
  assign cfg_if.ready = 1'b1;
  assign out_if.valid = out_valid_q;
  assign out_if.data = out_q;
  assign out_free = !out_valid_q || out_if.ready;

  wire in_fire = in_if.valid && in_if.ready;

  assign abs_rx = rx_q[15] ? 16'(-rx_q) : 16'(rx_q);
  assign abs_ry = ry_q[15] ? 16'(-ry_q) : 16'(ry_q);
  assign lhs = 33'(nx_q) * 33'(abs_ry);
  assign rhs = 33'(ny_q) * 33'(abs_rx);
  always_comb begin
    if (rx_q == 16'sd0) row_step = 1'b0;
    else if (ry_q == 16'sd0) row_step = 1'b1;
    else row_step = lhs < rhs;
  end

  assign tcol = 12'(signed'({1'b0, col_q, 1'b0})) - 12'(ScreenWidth);

  assign perp_new = (div_quot > 40'(MaxDist)) ? MaxDist : div_quot[19:0];

  function automatic logic signed [15:0] ray_fin(input logic signed [15:0] d,
                                                 input logic signed [27:0] t);
    logic [27:0] mag;
    logic [19:0] m;
    logic [39:0] prod;
    logic signed [28:0] q;
    logic signed [28:0] s;
    // floor of t / ScreenWidth by shift and reciprocal multiply
    mag = t[27] ? 28'(-t) + 28'(ScreenWidth - 1) : 28'(t);
    m = 20'(mag >> ScreenWidthShift);
    prod = 40'(m) * 40'(RecipFive);
    q = 29'(prod >> RecipShift);
    if (t[27]) q = -q;
    s = 29'(d) + q;
    if (s > 29'sd32767) return 16'sh7FFF;
    if (s < -29'sd32768) return 16'sh8000;
    return 16'(s);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [21:0] v);
    if (v > 22'sd32767) return 16'sh7FFF;
    if (v < -22'sd32768) return 16'sh8000;
    return 16'(v);
  endfunction

  logic inside_m;
  assign inside_m = (mx_q < (MapW+1)'(MapSize)) && (my_q < (MapW+1)'(MapSize));

  logic [16:0] wabs;
  logic signed [17:0] wraw;
  always_comb begin
    if (!side_q)
      wraw = 18'(signed'({1'b0, mx_q, 12'd0})) - 18'(signed'({1'b0, pos_x_q}))
             + (rx_q[15] ? 18'sd4096 : 18'sd0);
    else
      wraw = 18'(signed'({1'b0, my_q, 12'd0})) - 18'(signed'({1'b0, pos_y_q}))
             + (ry_q[15] ? 18'sd4096 : 18'sd0);
    wabs = wraw[17] ? 17'(-wraw) : 17'(wraw);
  end
  wire [15:0] adiv = side_q ? abs_ry : abs_rx;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_fire && in_if.data.mode) state_d = StRayMul;
      StRayMul: state_d = StRayAdd;
      StRayAdd: state_d = StInit;
      StInit: state_d = StCmp;
      StCmp: state_d = inside_m ? StStep : StDone;
      StStep: state_d = StRead;
      StRead: state_d = StTest;
      StTest: begin
        if (!inside_m) state_d = StDone;
        else if (wall_q) state_d = (adiv == 16'd0) ? StDone : StDist;
        else state_d = StStep;
      end
      StDist: state_d = StDivA;
      StDivA: if (!div_busy) state_d = (div_quot == 40'd0) ? StDone : StDivB;
      StDivB: if (!div_busy) state_d = StDone;
      StDone: if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    div_req = '0;
    if (state_q == StDist) begin
      div_req.start = 1'b1;
      div_req.num = {9'd0, wabs, 14'd0};
      div_req.den = {5'd0, adiv};
    end else if (state_q == StDivA && !div_busy && div_quot != 40'd0) begin
      div_req.start = 1'b1;
      div_req.num = 40'(ScreenHeight * OneQ12);
      div_req.den = {perp_new, 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      out_valid_q <= 1'b0;
      pos_x_q <= 16'd22528; pos_y_q <= 16'd22528;
      dir_x_q <= 16'sd16384; dir_y_q <= 16'sd0;
      plane_x_q <= 16'sd0; plane_y_q <= 16'sd10813;
      for (int i = 0; i < CellCnt; i++)
        map_q[i] <= start_wall(i / MapSize, i % MapSize);
    end else begin
      state_q <= state_d;
      if (state_q == StDone && out_free) out_valid_q <= 1'b1;
      else if (out_if.valid && out_if.ready) out_valid_q <= 1'b0;
      if (cfg_if.valid) begin
        unique case (cfg_if.data.index)
          RegPosX: pos_x_q <= cfg_if.data.data;
          RegPosY: pos_y_q <= cfg_if.data.data;
          RegDirX: dir_x_q <= cfg_if.data.data;
          RegDirY: dir_y_q <= cfg_if.data.data;
          RegPlaneX: plane_x_q <= cfg_if.data.data;
          RegPlaneY: plane_y_q <= cfg_if.data.data;
          default: ;
        endcase
      end
      if (in_fire && !in_if.data.mode)
        map_q[CellW'({in_if.data.cell_row[MapW-1:0], in_if.data.cell_col[MapW-1:0]})]
          <= in_if.data.cell_wall;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: if (in_fire) col_q <= in_if.data.column;
      StRayMul: begin
        px_q <= 28'(plane_x_q * tcol);
        py_q <= 28'(plane_y_q * tcol);
      end
      StRayAdd: begin
        rx_q <= ray_fin(dir_x_q, px_q);
        ry_q <= ray_fin(dir_y_q, py_q);
      end
      StInit: begin
        mx_q <= (MapW+1)'(pos_x_q[15:12]);
        my_q <= (MapW+1)'(pos_y_q[15:12]);
        nx_q <= rx_q[15] ? 17'(pos_x_q[11:0]) : 17'(OneQ12) - 17'(pos_x_q[11:0]);
        ny_q <= ry_q[15] ? 17'(pos_y_q[11:0]) : 17'(OneQ12) - 17'(pos_y_q[11:0]);
        side_q <= 1'b0;
        esc_q <= 1'b1;
      end
      StStep: begin
        if (row_step) begin
          mx_q <= rx_q[15] ? mx_q - 1'b1 : mx_q + 1'b1;
          nx_q <= nx_q + 17'(OneQ12);
          side_q <= 1'b0;
        end else begin
          my_q <= ry_q[15] ? my_q - 1'b1 : my_q + 1'b1;
          ny_q <= ny_q + 17'(OneQ12);
          side_q <= 1'b1;
        end
      end
      StRead: wall_q <= map_q[CellW'({mx_q[MapW-1:0], my_q[MapW-1:0]})];
      StTest: if (inside_m && wall_q) begin
        esc_q <= 1'b0;
        perp_q <= MaxDist;
        top_q <= 16'(ScreenHeight / 2);
        bottom_q <= 16'(ScreenHeight / 2);
      end
      StDivA: if (!div_busy) begin
        perp_q <= perp_new;
        top_q <= 16'sh8000;
        bottom_q <= 16'sh7FFF;
      end
      StDivB: if (!div_busy) begin
        top_q <= sat16(22'(ScreenHeight / 2) - 22'(signed'({1'b0, div_quot[20:0]})));
        bottom_q <= sat16(22'(ScreenHeight / 2) + 22'(signed'({1'b0, div_quot[20:0]})));
      end
      StDone: if (out_free) begin
        out_q.out_column <= col_q;
        out_q.escaped <= esc_q;
        out_q.wall_side <= esc_q ? 1'b0 : side_q;
        out_q.hit_row <= esc_q ? 4'd0 : 4'(mx_q);
        out_q.hit_col <= esc_q ? 4'd0 : 4'(my_q);
        out_q.perp_dist <= esc_q ? 20'd0 : perp_q;
        out_q.line_top <= esc_q ? 16'sd0 : top_q;
        out_q.line_bottom <= esc_q ? 16'sd0 : bottom_q;
      end
      default: ;
    endcase
  end

  `GDRC_ASSERT(a_busy_not_ready, clk_i, rst_ni, (state_q != StIdle) |-> !in_if.ready)
  `GDRC_ASSERT(a_done_valid, clk_i, rst_ni, (state_q == StDone) |=> out_if.valid)
  `GDRC_ASSERT(a_esc_zero, clk_i, rst_ni, (out_if.valid && out_if.data.escaped) |-> (out_if.data.perp_dist == 20'd0))
endmodule
`default_nettype wire
